FILE: design/lzss_decompressor_unit_defines.svh
`ifndef LZSS_DECOMPRESSOR_UNIT_DEFINES_SVH
`define LZSS_DECOMPRESSOR_UNIT_DEFINES_SVH

// Implication checked in the same cycle, masked while reset is high.
`define LZD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lzss decompressor: implication check failed");

// Implication checked in the next cycle, masked while reset is high.
`define LZD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lzss decompressor: next-cycle check failed");

// Implication checked in the next cycle at every edge, reset included.
`define LZD_ASSERT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("lzss decompressor: unconditional check failed");

`endif

FILE: design/lzd_pkg.sv
`default_nettype none

package lzd_pkg;

   // Width of one compressed or decompressed word.
   localparam int BYTE_W = 8;

   // Window write position after reset, and the fill below it.
   localparam logic [11:0] START_POS = 12'hFEE;
   localparam logic [BYTE_W-1:0] FILL_BYTE = 8'h20;

   // A back-reference copies three to eighteen bytes.
   localparam int MIN_RUN_LEN = 3;
   localparam int MAX_RUN_LEN = 18;
   localparam int RUN_W = 5;

endpackage

`default_nettype wire

FILE: design/lzd_ram.sv
`default_nettype none

module lzd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // One write port and one registered read port; a read of the entry being
   // written returns the old contents. The read data holds while rd_en is low.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: design/lzss_decompressor_unit.sv
// Channel  | Ports                                  | Direction | Word
// ---------+----------------------------------------+-----------+--------------------------
// request  | req_valid, req_stall, req_in_byte      | in        | one compressed byte
// response | rsp_valid, rsp_stall, rsp_out_byte,    | out       | one decompressed byte,
//          | rsp_last_of_run                        |           | flagged on the final one
//
// A second pair byte starts a copy of L bytes (3 to 18), one window read per
// cycle through the single read port of the history RAM. The request side
// stalls while a copy runs, and while a literal waits for the output register.
// Reset is synchronous; the window needs no clearing pass, as a fill count
// tells unwritten entries apart. A response stall freezes the copy.
`default_nettype none

module lzss_decompressor_unit
   import lzd_pkg::*;
#(
   parameter int WINDOW_SIZE = 4096
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [BYTE_W-1:0] req_in_byte,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic      [BYTE_W-1:0] rsp_out_byte,
   output logic                   rsp_last_of_run
);

   localparam int AW = $clog2(WINDOW_SIZE);
   localparam logic [AW-1:0] START = AW'(START_POS);
   localparam logic [AW:0] FILL_MAX = (AW+1)'(WINDOW_SIZE);

   typedef enum logic [1:0] {
      PH_FLAG  = 2'd0,
      PH_OP    = 2'd1,
      PH_PAIR2 = 2'd2
   } phase_type;

   // Decoder state.
   phase_type         phase_ff;
   logic [7:0]        flag_shift_ff;
   logic [3:0]        flags_left_ff;
   logic [BYTE_W-1:0] offset_low_ff;
   logic [AW-1:0]     wr_pos_ff;
   logic [AW:0]       fill_ff;

   // Copy sequencer and the read stage behind it.
   logic              copy_active_ff;
   logic [AW-1:0]     rd_pos_ff;
   logic [RUN_W-1:0]  run_left_ff;
   logic              s1_valid_ff;
   logic              s1_last_ff;
   logic              s1_fwd_hit_ff;
   logic [BYTE_W-1:0] s1_fwd_data_ff;
   logic              s1_written_ff;
   logic [BYTE_W-1:0] s1_init_ff;

   // Output register.
   logic              rsp_valid_ff;
   logic [BYTE_W-1:0] rsp_byte_ff;
   logic              rsp_last_ff;

   logic              out_free;
   logic              lit_pending;
   logic              req_accept;
   logic              lit_fire;
   logic              pair_fire;
   logic              s1_adv;
   logic              issue;
   logic              wr_en;
   logic [BYTE_W-1:0] wr_data;
   logic [BYTE_W-1:0] ram_rd_data;
   logic [BYTE_W-1:0] s1_value;
   logic [AW-1:0]     rd_age;
   logic              rd_written;
   logic [3:0]        flags_left_in;
   logic [AW-1:0]     pair_pos;
   logic [RUN_W-1:0]  pair_len;

   // Handshake on both sides.
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign lit_pending = (phase_ff == PH_OP) && flag_shift_ff[0];
   assign req_stall   = copy_active_ff || s1_valid_ff || (lit_pending && !out_free);
   assign req_accept  = req_valid && !req_stall;
   assign lit_fire    = req_accept && lit_pending;
   assign pair_fire   = req_accept && (phase_ff == PH_PAIR2);

   // The read stage moves on when the output register can take its word.
   assign s1_adv = s1_valid_ff && out_free;
   assign issue  = copy_active_ff && (!s1_valid_ff || s1_adv);

   // Select the copied byte: forwarded write, stored entry or reset contents.
   always_comb begin
      if (s1_fwd_hit_ff) begin
         s1_value = s1_fwd_data_ff;
      end else if (s1_written_ff) begin
         s1_value = ram_rd_data;
      end else begin
         s1_value = s1_init_ff;
      end
   end

   // Literals and copied bytes are never written in the same cycle.
   assign wr_en   = lit_fire || s1_adv;
   assign wr_data = lit_fire ? req_in_byte : s1_value;

   // Writes go out in order from START, so the fill count marks written entries.
   assign rd_age     = rd_pos_ff - START;
   assign rd_written = ({1'b0, rd_age} < fill_ff);

   // Pair decoding from the held first byte and the current second byte.
   assign pair_pos = AW'({req_in_byte[7:4], offset_low_ff});
   assign pair_len = RUN_W'(req_in_byte[3:0]) + RUN_W'(MIN_RUN_LEN);

   assign flags_left_in = (flags_left_ff != 4'd0) ? flags_left_ff - 4'd1 : 4'd0;

   lzd_ram #(
      .WIDTH(BYTE_W),
      .DEPTH(WINDOW_SIZE)
   ) u_history (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_pos_ff),
      .wr_data(wr_data),
      .rd_en  (issue),
      .rd_addr(rd_pos_ff),
      .rd_data(ram_rd_data)
   );

   // Decoder, copy sequencer, read stage and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_FLAG;
         flag_shift_ff  <= '0;
         flags_left_ff  <= '0;
         offset_low_ff  <= '0;
         wr_pos_ff      <= START;
         fill_ff        <= '0;
         copy_active_ff <= 1'b0;
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         // Input words step through flag, operation and pair phases.
         if (req_accept) begin
            unique case (phase_ff)
               PH_OP: begin
                  if (flag_shift_ff[0]) begin
                     flag_shift_ff <= flag_shift_ff >> 1;
                     flags_left_ff <= flags_left_in;
                     phase_ff      <= (flags_left_in == 4'd0) ? PH_FLAG : PH_OP;
                  end else begin
                     offset_low_ff <= req_in_byte;
                     phase_ff      <= PH_PAIR2;
                  end
               end
               PH_PAIR2: begin
                  flag_shift_ff <= flag_shift_ff >> 1;
                  flags_left_ff <= flags_left_in;
                  phase_ff      <= (flags_left_in == 4'd0) ? PH_FLAG : PH_OP;
               end
               default: begin
                  flag_shift_ff <= req_in_byte;
                  flags_left_ff <= 4'd8;
                  phase_ff      <= PH_OP;
               end
            endcase
         end

         // Window write pointer and fill count.
         if (wr_en) begin
            wr_pos_ff <= wr_pos_ff + 1'b1;
            if (fill_ff != FILL_MAX) begin
               fill_ff <= fill_ff + 1'b1;
            end
         end

         // Copy sequencer: one window read per cycle unless a response stall holds it.
         if (pair_fire) begin
            copy_active_ff <= 1'b1;
            rd_pos_ff      <= pair_pos;
            run_left_ff    <= pair_len;
         end else if (issue) begin
            rd_pos_ff   <= rd_pos_ff + 1'b1;
            run_left_ff <= run_left_ff - 1'b1;
            if (run_left_ff == RUN_W'(1)) begin
               copy_active_ff <= 1'b0;
            end
         end

         // Read stage, with forwarding of a write to the entry being read.
         if (issue) begin
            s1_valid_ff    <= 1'b1;
            s1_last_ff     <= (run_left_ff == RUN_W'(1));
            s1_fwd_hit_ff  <= wr_en && (rd_pos_ff == wr_pos_ff);
            s1_fwd_data_ff <= wr_data;
            s1_written_ff  <= rd_written;
            s1_init_ff     <= (rd_pos_ff < START) ? FILL_BYTE : '0;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end

         // Output register.
         if (lit_fire) begin
            rsp_valid_ff <= 1'b1;
            rsp_byte_ff  <= req_in_byte;
            rsp_last_ff  <= 1'b1;
         end else if (s1_adv) begin
            rsp_valid_ff <= 1'b1;
            rsp_byte_ff  <= s1_value;
            rsp_last_ff  <= s1_last_ff;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_last_of_run = rsp_last_ff;

endmodule

`default_nettype wire

FILE: design/lzd_checker.sv
`default_nettype none

`include "lzss_decompressor_unit_defines.svh"

module lzd_checker
   import lzd_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire logic [BYTE_W-1:0] rsp_out_byte,
   input wire logic              rsp_last_of_run
);

   logic [RUN_W-1:0] run_cnt_ff;
   logic             req_take;
   logic             rsp_take;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;

   // Count the words of the run delivered so far.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_cnt_ff <= '0;
      end else if (rsp_take) begin
         run_cnt_ff <= rsp_last_of_run ? '0 : run_cnt_ff + 1'b1;
      end
   end

   // A stalled response word holds its value.
   `LZD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last_of_run))

   // No compressed byte is taken while a run is only partly delivered.
   `LZD_ASSERT_IMP(a_no_take_mid_run, clock, reset, req_take, !(rsp_valid && !rsp_last_of_run))

   // A run never exceeds the longest back-reference.
   `LZD_ASSERT_IMP(a_run_len, clock, reset, rsp_take && !rsp_last_of_run, run_cnt_ff < RUN_W'(MAX_RUN_LEN - 1))

   // The output register is empty straight after reset.
   `LZD_ASSERT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid)

endmodule

bind lzss_decompressor_unit lzd_checker u_lzd_checker (.*);

`default_nettype wire
